// File: hw/rtl/q2e_pkg.sv
package q2e_pkg;

  // Field and datapath widths
  localparam int QW      = 16;  // quaternion component, Q2.14
  localparam int PW      = 32;  // component product, scale 2^28
  localparam int AW      = 34;  // atan2 argument, scale 2^28
  localparam int CW      = 37;  // CORDIC x/y lanes, room for the gain
  localparam int ZW      = 28;  // angle accumulator, scale 2^24
  localparam int MW      = 28;  // sine magnitude below one
  localparam int SW      = 58;  // square root remainder and root work width
  localparam int SQW     = 29;  // root of 1 - s^2, scale 2^28
  localparam int NSTG    = 20;  // CORDIC iterations
  localparam int SQ_STEPS = 29; // one root bit per stage
  localparam int NLANE   = 3;   // roll, pitch, yaw

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [AW-1:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [ZW-1:0] ROUND_HALF  = 28'sd1024;
  localparam logic signed [16:0]   OUT_PI      = 17'sd25736;
  localparam logic signed [16:0]   OUT_HALF_PI = 17'sd12868;

  // atan(2^-i) at scale 2^24, rounded to nearest
  localparam logic signed [ZW-1:0] ATAN_TAB [NSTG] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117,   28'sd262123,  28'sd131069,  28'sd65536,   28'sd32768,
    28'sd16384,    28'sd8192,    28'sd4096,    28'sd2048,    28'sd1024,
    28'sd512,      28'sd256,     28'sd128,     28'sd64,      28'sd32
  };

  // atan2 arguments carried alongside the square root
  typedef struct packed {
    logic signed [AW-1:0] sr;
    logic signed [AW-1:0] cr;
    logic signed [AW-1:0] sp;
    logic signed [AW-1:0] sy;
    logic signed [AW-1:0] cy;
    logic                 lock;
  } atan_args_t;

  // One finished result
  typedef struct packed {
    logic              lock;
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } euler_res_t;

endpackage

// File: hw/rtl/q2e_front.sv
module q2e_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [15:0]           quat_x_i,
  input  logic signed [15:0]           quat_y_i,
  input  logic signed [15:0]           quat_z_i,
  input  logic signed [15:0]           quat_w_i,
  output logic                         valid_o,
  output logic [56:0]                  rem_o,
  output q2e_pkg::atan_args_t          args_o
);
  import q2e_pkg::*;

  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  logic [2:0]           vld_q;
  atan_args_t           args_d, args2_q, args3_q, args4_q;
  logic signed [AW-2:0] s_sr, s_cr, s_sp, s_sy, s_cy;
  logic [AW-1:0]        mag_d;
  logic [MW-1:0]        mag_q;
  logic [2*MW-1:0]      sq_q;
  logic [56:0]          rem_q;

  // Stage 1: component products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // Stage 2: product sums, sine magnitude and clamp test
  always_comb begin
    s_sr = (AW-1)'(wx_q) + (AW-1)'(yz_q);
    s_cr = (AW-1)'(xx_q) + (AW-1)'(yy_q);
    s_sp = (AW-1)'(wy_q) - (AW-1)'(zx_q);
    s_sy = (AW-1)'(wz_q) + (AW-1)'(xy_q);
    s_cy = (AW-1)'(yy_q) + (AW-1)'(zz_q);
    args_d.sr   = {s_sr, 1'b0};
    args_d.cr   = ONE_Q28 - {s_cr, 1'b0};
    args_d.sp   = {s_sp, 1'b0};
    args_d.sy   = {s_sy, 1'b0};
    args_d.cy   = ONE_Q28 - {s_cy, 1'b0};
    mag_d       = args_d.sp[AW-1] ? -args_d.sp : args_d.sp;
    args_d.lock = |mag_d[AW-1:MW];
  end

  // Stages 2 to 4: square the magnitude, then form 1 - s^2 at scale 2^56
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      args2_q <= args_d;
      mag_q   <= mag_d[MW-1:0];
      args3_q <= args2_q;
      sq_q    <= mag_q * mag_q;
      args4_q <= args3_q;
      rem_q   <= {1'b1, 56'd0} - {1'b0, sq_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[1:0], valid_i};
      valid_o <= vld_q[2];
    end
  end

  assign rem_o  = rem_q;
  assign args_o = args4_q;

endmodule

// File: hw/rtl/q2e_sqrt.sv
module q2e_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [56:0]                  rem_i,
  input  q2e_pkg::atan_args_t          args_i,
  output logic                         valid_o,
  output logic [q2e_pkg::SQW-1:0]      root_o,
  output q2e_pkg::atan_args_t          args_o
);
  import q2e_pkg::*;

  logic [SW-1:0] v_q    [SQ_STEPS];
  logic [SW-1:0] r_q    [SQ_STEPS];
  atan_args_t    args_q [SQ_STEPS];
  logic          vld_q  [SQ_STEPS];

  // One root bit per stage, test bit walking down from 2^56
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SW-1:0] v_c, r_c, t_c, v_d, r_d, bit_c;
    atan_args_t    a_c;
    logic          vl_c;

    if (k == 0) begin : g_first
      assign v_c  = SW'(rem_i);
      assign r_c  = '0;
      assign a_c  = args_i;
      assign vl_c = valid_i;
    end else begin : g_next
      assign v_c  = v_q[k-1];
      assign r_c  = r_q[k-1];
      assign a_c  = args_q[k-1];
      assign vl_c = vld_q[k-1];
    end

    always_comb begin
      bit_c = SW'(1) << (2 * (SQ_STEPS - 1 - k));
      t_c   = r_c + bit_c;
      if (v_c >= t_c) begin
        v_d = v_c - t_c;
        r_d = (r_c >> 1) + bit_c;
      end else begin
        v_d = v_c;
        r_d = r_c >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= v_d;
        r_q[k]    <= r_d;
        args_q[k] <= a_c;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vl_c;
      end
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign root_o  = r_q[SQ_STEPS-1][SQW-1:0];
  assign args_o  = args_q[SQ_STEPS-1];

endmodule

// File: hw/rtl/q2e_cordic.sv
module q2e_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [q2e_pkg::SQW-1:0]      root_i,
  input  q2e_pkg::atan_args_t          args_i,
  output logic                         valid_o,
  output q2e_pkg::euler_res_t          res_o
);
  import q2e_pkg::*;

  logic signed [CW-1:0] yin [NLANE];
  logic signed [CW-1:0] xin [NLANE];

  logic signed [CW-1:0] x_q  [NSTG+1][NLANE];
  logic signed [CW-1:0] y_q  [NSTG+1][NLANE];
  logic signed [ZW-1:0] z_q  [NSTG+1][NLANE];
  logic                 zr_q [NSTG+1][NLANE];
  logic                 lk_q [NSTG+1];
  logic                 ng_q [NSTG+1];
  logic                 vld_q [NSTG+1];

  logic signed [16:0]   ang  [NLANE];
  euler_res_t           res_d;

  // Lane arguments: roll, pitch (sine over root), yaw
  always_comb begin
    yin[LANE_ROLL]  = CW'(args_i.sr);
    xin[LANE_ROLL]  = CW'(args_i.cr);
    yin[LANE_PITCH] = CW'(args_i.sp);
    xin[LANE_PITCH] = CW'($signed({1'b0, root_i}));
    yin[LANE_YAW]   = CW'(args_i.sy);
    xin[LANE_YAW]   = CW'(args_i.cy);
  end

  // Pre-rotation: fold the left half plane by a quarter turn
  for (genvar l = 0; l < NLANE; l++) begin : g_pre
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zr_q[0][l] <= (xin[l] == '0) && (yin[l] == '0);
        if (xin[l][CW-1] && !yin[l][CW-1]) begin
          x_q[0][l] <= yin[l];
          y_q[0][l] <= -xin[l];
          z_q[0][l] <= ANG_HALF_PI;
        end else if (xin[l][CW-1]) begin
          x_q[0][l] <= -yin[l];
          y_q[0][l] <= xin[l];
          z_q[0][l] <= -ANG_HALF_PI;
        end else begin
          x_q[0][l] <= xin[l];
          y_q[0][l] <= yin[l];
          z_q[0][l] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lk_q[0] <= args_i.lock;
      ng_q[0] <= args_i.sp[AW-1];
    end
  end

  // Vectoring iterations, one per stage, all lanes side by side
  for (genvar i = 0; i < NSTG; i++) begin : g_iter
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic signed [CW-1:0] dx, dy;
      logic                 pos;
      assign dx  = y_q[i][l] >>> i;
      assign dy  = x_q[i][l] >>> i;
      assign pos = !y_q[i][l][CW-1] && (y_q[i][l] != '0);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          zr_q[i+1][l] <= zr_q[i][l];
          if (pos) begin
            x_q[i+1][l] <= x_q[i][l] + dx;
            y_q[i+1][l] <= y_q[i][l] - dy;
            z_q[i+1][l] <= z_q[i][l] + ATAN_TAB[i];
          end else begin
            x_q[i+1][l] <= x_q[i][l] - dx;
            y_q[i+1][l] <= y_q[i][l] + dy;
            z_q[i+1][l] <= z_q[i][l] - ATAN_TAB[i];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lk_q[i+1] <= lk_q[i];
        ng_q[i+1] <= ng_q[i];
      end
    end
  end

  // Valid bits follow the data through every stage
  for (genvar i = 0; i <= NSTG; i++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= (i == 0) ? valid_i : vld_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Round to Q3.13 (half up), clamp, apply zero and gimbal-lock overrides
  for (genvar l = 0; l < NLANE; l++) begin : g_rnd
    logic signed [ZW-1:0] zs;
    logic signed [16:0]   lim;
    assign zs  = (z_q[NSTG][l] + ROUND_HALF) >>> 11;
    assign lim = (l == LANE_PITCH) ? OUT_HALF_PI : OUT_PI;
    always_comb begin
      if (zr_q[NSTG][l]) begin
        ang[l] = '0;
      end else if (zs > ZW'(lim)) begin
        ang[l] = lim;
      end else if (zs < -ZW'(lim)) begin
        ang[l] = -lim;
      end else begin
        ang[l] = zs[16:0];
      end
    end
  end

  always_comb begin
    res_d.roll = ang[LANE_ROLL][15:0];
    res_d.yaw  = ang[LANE_YAW][15:0];
    res_d.lock = lk_q[NSTG];
    if (lk_q[NSTG]) begin
      res_d.pitch = ng_q[NSTG] ? -OUT_HALF_PI[14:0] : OUT_HALF_PI[14:0];
    end else begin
      res_d.pitch = ang[LANE_PITCH][14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld_q[NSTG];
    end
  end

endmodule

// File: hw/rtl/quaternion_to_euler_angles_top.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: quat_x, quat_y, quat_z, quat_w (Q2.14)
// m_axis    out  tdata: roll (Q3.13), pitch (Q2.13), yaw (Q3.13); tuser: gimbal_lock
//
// One quaternion per cycle sustained while the skid slot is free; from input
// beat to output beat: 4 front stages, 29 square root stages, 22 CORDIC
// stages, output register. The 29-step square root sets the depth.
// Reset clears all valid bits, including the output and skid valid flags.
// A stalled output holds in its register while one more result parks in
// the skid slot; the pipeline freezes only once that slot is full.
module quaternion_to_euler_angles_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_x, quat_y, quat_z, quat_w
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // roll[15:0], pitch[14:0], yaw[15:0], pad
  output logic        m_axis_tuser_o    // gimbal_lock
);
  import q2e_pkg::*;

  logic        en;
  logic        fr_vld, sq_vld, co_vld, push;
  logic [56:0] fr_rem;
  atan_args_t  fr_args, sq_args;
  logic [SQW-1:0] sq_root;
  euler_res_t  co_res;

  logic        out_v_d, out_v_q, skid_v_d, skid_v_q;
  euler_res_t  out_d, out_q, skid_d, skid_q;

  // Advance the whole pipeline while the skid slot is free
  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;
  assign push            = en && co_vld;

  q2e_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .quat_x_i (s_axis_tdata_i[15:0]),
    .quat_y_i (s_axis_tdata_i[31:16]),
    .quat_z_i (s_axis_tdata_i[47:32]),
    .quat_w_i (s_axis_tdata_i[63:48]),
    .valid_o  (fr_vld),
    .rem_o    (fr_rem),
    .args_o   (fr_args)
  );

  q2e_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rem_i   (fr_rem),
    .args_i  (fr_args),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .args_o  (sq_args)
  );

  q2e_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .root_i  (sq_root),
    .args_i  (sq_args),
    .valid_o (co_vld),
    .res_o   (co_res)
  );

  // Output register with one skid slot
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || m_axis_tready_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = push;
        if (push) begin
          out_d = co_res;
        end
      end
    end else if (push) begin
      skid_v_d = 1'b1;
      skid_d   = co_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {1'b0, out_q.yaw, out_q.pitch, out_q.roll};
  assign m_axis_tuser_o  = out_q.lock;

  // Skid slot only fills behind a waiting output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid slot full with empty output register");

  // Gimbal lock always reports pitch at plus or minus pi/2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.lock) |->
      (out_q.pitch == 15'sd12868 || out_q.pitch == -15'sd12868))
    else $error("gimbal lock beat with unclamped pitch");

  // Roll and yaw stay within plus or minus pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.roll <= 16'sd25736 && out_q.roll >= -16'sd25736 &&
                 out_q.yaw <= 16'sd25736 && out_q.yaw >= -16'sd25736))
    else $error("roll or yaw beyond pi");

endmodule

// File: dv/quaternion_to_euler_angles_top_tb.sv
`timescale 1ns / 1ps

module quaternion_to_euler_angles_top_tb;

  localparam int ANG_STAGES = 20;
  localparam longint ANG_HALF_PI_Q24 = 64'sd26353589;
  localparam longint ONE_Q28_L = 64'sd268435456;
  localparam longint PI_Q13 = 64'sd25736;
  localparam longint HALF_PI_Q13 = 64'sd12868;
  localparam int PIPE_DEPTH = 56;
  localparam int N_RANDOM = 600;

  typedef struct packed {
    logic              lock;
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } euler_t;

  typedef struct {
    logic signed [15:0] qx, qy, qz, qw;
    bit                 has_exp;
    euler_t             exp_res;
  } quat_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // quat_x, quat_y, quat_z, quat_w
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;   // roll[15:0], pitch[14:0], yaw[15:0], pad
  logic        m_axis_tuser_o;   // gimbal_lock

  longint atan_q24 [ANG_STAGES] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  euler_t    angles_due[$];
  quat_row_t dir_rows[$];
  int        fail_cnt;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        recv_hold;

  quaternion_to_euler_angles_top dut (.*);

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // vectoring-mode CORDIC at angle scale 2^24
  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_HALF_PI_Q24;
      end else begin
        t = x; x = -y; y = t; z = -ANG_HALF_PI_Q24;
      end
    end
    for (int i = 0; i < ANG_STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q24[i];
      end else begin
        x -= dx; y += dy; z -= atan_q24[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(longint z, longint lim);
    longint r;
    r = shr_floor(z + 1024, 11);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(longint x, longint y, longint z, longint w);
    euler_t e;
    longint sr, cr, sp, sy, cy, mag, c, p;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q28_L - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q28_L - 2 * (y * y + z * z);
    e.roll = 16'(round_q13(vec_atan2(sr, cr), PI_Q13));
    e.yaw = 16'(round_q13(vec_atan2(sy, cy), PI_Q13));
    mag = (sp < 0) ? -sp : sp;
    if (mag >= ONE_Q28_L) begin
      e.lock = 1'b1;
      p = (sp > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
    end else begin
      c = root_floor((64'sd1 <<< 56) - mag * mag);
      e.lock = 1'b0;
      p = round_q13(vec_atan2(sp, c), HALF_PI_Q13);
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  function automatic void add_row(int x, int y, int z, int w, bit he = 0,
                                  int r = 0, int p = 0, int yw = 0, bit lk = 0);
    quat_row_t row;
    row.qx = 16'(x); row.qy = 16'(y); row.qz = 16'(z); row.qw = 16'(w);
    row.has_exp = he;
    row.exp_res.roll = 16'(r); row.exp_res.pitch = 15'(p);
    row.exp_res.yaw = 16'(yw); row.exp_res.lock = lk;
    dir_rows.push_back(row);
  endfunction

  // random unit-ish quaternion component, mostly within +-1.0
  function automatic logic signed [15:0] rand_comp();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // drive one beat at the falling edge, hold it until the handshake
  task automatic send_quat(logic signed [15:0] x, y, z, w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {w, z, y, x};
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    if (dir_rows.size() != 0 && dir_rows[0].has_exp && dir_rows[0].qx == x &&
        dir_rows[0].qy == y && dir_rows[0].qz == z && dir_rows[0].qw == w)
      angles_due.push_back(dir_rows[0].exp_res);
    else
      angles_due.push_back(quat_to_euler(x, y, z, w));
    @(negedge clk_i);
  endtask

  // receiver: random ready, with a long hold-off when asked
  always @(negedge clk_i) begin
    if (recv_hold) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    euler_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.roll = m_axis_tdata_o[15:0];
      got.pitch = m_axis_tdata_o[30:16];
      got.yaw = m_axis_tdata_o[46:31];
      got.lock = m_axis_tuser_o;
      if (angles_due.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = angles_due.pop_front();
        if (got.roll !== want.roll) begin
          $error("roll_angle exp %0d got %0d", want.roll, got.roll); fail_cnt++;
        end
        if (got.pitch !== want.pitch) begin
          $error("pitch_angle exp %0d got %0d", want.pitch, got.pitch); fail_cnt++;
        end
        if (got.yaw !== want.yaw) begin
          $error("yaw_angle exp %0d got %0d", want.yaw, got.yaw); fail_cnt++;
        end
        if (got.lock !== want.lock) begin
          $error("gimbal_lock exp %0d got %0d", want.lock, got.lock); fail_cnt++;
        end
      end
    end
  end

  // overall time limit
  initial begin
    #20ms;
    $display("quaternion_to_euler_angles_top: mismatch");
    $finish;
  end

  initial begin
    int wait_cnt;
    quat_row_t row;
    logic signed [15:0] a, b, c, d;
    fail_cnt = 0;
    recv_hold = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 69;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;

    // identity, all-zero input, gimbal lock both signs, extremes
    add_row(0, 0, 0, 16384, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(0, 8192, 0, 32767, 1, 0, 12868, 0, 1);
    add_row(0, -8192, 0, 32767, 1, 0, -12868, 0, 1);
    add_row(16384, 0, 0, 0);
    add_row(0, 16384, 0, 0);
    add_row(0, 0, 16384, 0);
    add_row(0, 0, 0, -16384);
    add_row(-16384, 0, 0, 0);
    add_row(0, 0, -16384, 0);
    add_row(32767, 32767, 32767, 32767);
    add_row(-32768, -32768, -32768, -32768);
    add_row(-32768, 32767, -32768, 32767);
    add_row(32767, -32768, 32767, -32768);
    add_row(8192, 8192, 8192, 8192);
    add_row(-8192, 8192, -8192, 8192);
    add_row(11585, 0, 0, 11585);
    add_row(0, 0, 11585, -11585);
    add_row(1, -1, 1, -1);
    add_row(21845, 0, 0, 0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    while (dir_rows.size() != 0) begin
      row = dir_rows[0];
      send_quat(row.qx, row.qy, row.qz, row.qw);
      void'(dir_rows.pop_front());
    end

    // hold off the receiver long enough to back the pipeline up
    fork
      begin
        recv_hold = 1'b1;
        for (wait_cnt = 0; wait_cnt < 3 * PIPE_DEPTH; wait_cnt++) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        send_idle_pct = 0;
        for (int i = 0; i < PIPE_DEPTH + 20; i++)
          send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    join

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 69; recv_idle_pct = 35;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (i == 0) begin
        send_idle_pct = 35;
      end
      if ($urandom_range(0, 9) == 0) begin
        // near gimbal lock: w close to y, z close to +-x
        a = rand_comp();
        b = 16'(a + $signed($urandom_range(0, 8)) - 4);
        c = rand_comp();
        d = ($urandom_range(0, 1) == 1) ? c : -c;
        send_quat(c, a, 16'(d + $signed($urandom_range(0, 4)) - 2), b);
      end else begin
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
    s_axis_tvalid_i <= 1'b0;

    wait (angles_due.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("quaternion_to_euler_angles_top: match");
    end else begin
      $display("quaternion_to_euler_angles_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/q2e_pkg.sv
hw/rtl/q2e_front.sv
hw/rtl/q2e_sqrt.sv
hw/rtl/q2e_cordic.sv
hw/rtl/quaternion_to_euler_angles_top.sv
dv/quaternion_to_euler_angles_top_tb.sv
